>>> rtl/frfl_pkg.sv
// Shared types and codes for the fixed record free-list store.
// Used by the top level; depends on nothing else.
package frfl_pkg;

  // Fixed widths of the item fields.
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 10;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;

  // Operation codes; the fourth code is a no-op.
  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_READ = 2'd1,
    OP_DEL  = 2'd2
  } op_t;

  // Status codes returned with every result item.
  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_DELETED = 2'd1,
    STS_FULL    = 2'd2,
    STS_RANGE   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

>>> rtl/frfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used by the top level for every store.
module frfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/fixed_record_free_list_store_unit.sv
// Top level of the fixed record free-list store.
// Depends on frfl_pkg (codes and widths) and frfl_ram (both stores).
//
// The block keeps SLOTS fixed slots, each with a DATA_BITS payload. An input
// item carries an operation (add, read, delete), a slot index and a payload.
// Add fills the most recently freed slot, or the next never-used slot, and
// reports it; read returns a slot's payload and live mark; delete pushes a
// live slot onto a last-in first-out free list linked through the slots.
// Every input item produces exactly one result item with a status, the slot,
// the read payload, the live mark and the free-list head after the step.
//
// Both channels use valid/stall; an item moves on an edge with valid high and
// stall low. An accepted item reads both memories at the accept edge; the
// execute state that follows decides, writes back and loads the result
// register. The input stalls during execute, so no new item is taken until
// the last one has executed; the registered read data of the memories is
// why that execute state is needed. A new item is accepted while a finished
// result still waits; if the receiver keeps stalling, execution of that new
// item waits until the result register is free, and the input stays stalled
// meanwhile.
//
// Reset clears the free-list head, the used-slot count and the result valid.
// No clearing pass is needed: the read data of slots at or above the used
// count is never used, and every slot below it has been written by an add.
module fixed_record_free_list_store_unit #(
  parameter int SLOTS     = 1024,
  parameter int DATA_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [frfl_pkg::OP_W-1:0]           in_op,
  input  logic [frfl_pkg::SLOT_W-1:0]         in_slot,
  input  logic [frfl_pkg::DATA_W-1:0]         in_record_data,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [frfl_pkg::STATUS_W-1:0]       out_status,
  output logic [frfl_pkg::SLOT_W-1:0]         out_result_slot,
  output logic [frfl_pkg::DATA_W-1:0]         out_read_data,
  output logic                                out_slot_live,
  output logic [frfl_pkg::SLOT_W-1:0]         out_free_head,
  output logic                                out_free_head_valid
);

  // Slot index width, used-count width, compare width and meta word width.
  localparam int SW  = $clog2(SLOTS);
  localparam int UW  = SW + 1;
  localparam int SLW = frfl_pkg::SLOT_W;
  localparam int DW  = frfl_pkg::DATA_W;
  localparam int CW  = (UW > SLW) ? UW : SLW;
  localparam int MW  = SW + 2;
  localparam logic [UW-1:0] SLOTS_C = UW'(SLOTS);

  // The meta word of a slot holds its live mark on top, then the free-list
  // link: a valid bit and the index of the next free slot.
  localparam int LIVE_BIT = MW - 1;
  localparam int LINK_BIT = SW;

  // Sequencer.
  frfl_pkg::state_t state_r, state_nxt;
  logic accept;
  logic exec_go;

  // Architectural state held in registers.
  logic [SW-1:0] head_index_r, head_index_nxt;
  logic          head_present_r, head_present_nxt;
  logic [UW-1:0] used_count_r, used_count_nxt;

  // The accepted item, held through the execute cycle.
  logic [SLW-1:0]       slot_r;
  logic [1:0]           op_r;
  logic [DATA_BITS-1:0] data_r;

  // Accept-time read addresses.
  logic [CW-1:0] in_req_ext;
  logic [SW-1:0] in_req_idx;
  logic [SW-1:0] meta_raddr;

  // Memory ports.
  logic [MW-1:0]        meta_rd;
  logic [DATA_BITS-1:0] pay_rd;
  logic                 meta_we;
  logic [SW-1:0]        meta_waddr;
  logic [MW-1:0]        meta_wdata;
  logic                 pay_we;

  // Execute-cycle decision.
  logic [CW-1:0]        req_ext;
  logic [SW-1:0]        req_idx;
  logic                 req_in_range;
  logic                 meta_live;
  logic [1:0]           status;
  logic [CW-1:0]        rslot_ext;
  logic [DATA_BITS-1:0] rdata;
  logic                 live;

  // Result register.
  logic                        out_valid_r;
  logic [frfl_pkg::STATUS_W-1:0] out_status_r;
  logic [SLW-1:0]              out_result_slot_r;
  logic [DW-1:0]               out_read_data_r;
  logic                        out_slot_live_r;
  logic [SLW-1:0]              out_free_head_r;
  logic                        out_free_head_valid_r;

  // ---------------------------------------------------------------------------
  // Sequencer: idle accepts an item, execute finishes it once the result
  // register can take the result.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frfl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = frfl_pkg::ST_EXEC;
        end
      end
      frfl_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt = frfl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = frfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != frfl_pkg::ST_IDLE);
    accept   = in_valid && (state_r == frfl_pkg::ST_IDLE);
    exec_go  = (state_r == frfl_pkg::ST_EXEC) && (!out_valid_r || !out_stall);
  end

  // ---------------------------------------------------------------------------
  // Read addresses at acceptance. An add with a nonempty free list needs the
  // head slot's link; every other operation reads the requested slot's live
  // mark (and payload for read). A full-store add also reports the requested
  // slot's live mark, so it reads that slot as well.
  // ---------------------------------------------------------------------------
  assign in_req_ext = CW'(in_slot);
  assign in_req_idx = in_req_ext[SW-1:0];
  assign meta_raddr = ((in_op == frfl_pkg::OP_ADD) && head_present_r) ?
                      head_index_r : in_req_idx;

  frfl_ram #(
    .WIDTH(MW),
    .DEPTH(SLOTS)
  ) u_meta_ram (
    .clk    (clk),
    .wr_en  (exec_go && meta_we),
    .wr_addr(meta_waddr),
    .wr_data(meta_wdata),
    .rd_en  (accept),
    .rd_addr(meta_raddr),
    .rd_data(meta_rd)
  );

  frfl_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(SLOTS)
  ) u_payload_ram (
    .clk    (clk),
    .wr_en  (exec_go && pay_we),
    .wr_addr(meta_waddr),
    .wr_data(data_r),
    .rd_en  (accept),
    .rd_addr(in_req_idx),
    .rd_data(pay_rd)
  );

  // ---------------------------------------------------------------------------
  // Execute: decide the step from the read data and the held item.
  // ---------------------------------------------------------------------------
  assign req_ext      = CW'(slot_r);
  assign req_idx      = req_ext[SW-1:0];
  assign req_in_range = (req_ext < CW'(used_count_r));
  assign meta_live    = meta_rd[LIVE_BIT];

  always_comb begin
    status           = frfl_pkg::STS_OK;
    rslot_ext        = req_ext;
    rdata            = '0;
    live             = 1'b0;
    head_index_nxt   = head_index_r;
    head_present_nxt = head_present_r;
    used_count_nxt   = used_count_r;
    meta_we          = 1'b0;
    pay_we           = 1'b0;
    meta_waddr       = req_idx;
    meta_wdata       = {1'b1, 1'b0, SW'(0)};
    case (op_r)
      frfl_pkg::OP_ADD: begin
        if (head_present_r) begin
          // Reuse the most recently freed slot and pop it off the list.
          meta_we          = 1'b1;
          pay_we           = 1'b1;
          meta_waddr       = head_index_r;
          head_present_nxt = meta_rd[LINK_BIT];
          head_index_nxt   = meta_rd[LINK_BIT] ? meta_rd[SW-1:0] : '0;
          rslot_ext        = CW'(head_index_r);
          live             = 1'b1;
        end else if (used_count_r < SLOTS_C) begin
          // Append after the used slots.
          meta_we        = 1'b1;
          pay_we         = 1'b1;
          meta_waddr     = used_count_r[SW-1:0];
          used_count_nxt = used_count_r + UW'(1);
          rslot_ext      = CW'(used_count_r);
          live           = 1'b1;
        end else begin
          status = frfl_pkg::STS_FULL;
          live   = req_in_range && meta_live;
        end
      end
      frfl_pkg::OP_READ: begin
        if (!req_in_range) begin
          status = frfl_pkg::STS_RANGE;
        end else begin
          rdata = pay_rd;
          live  = meta_live;
        end
      end
      frfl_pkg::OP_DEL: begin
        if (!req_in_range) begin
          status = frfl_pkg::STS_RANGE;
        end else if (!meta_live) begin
          status = frfl_pkg::STS_DELETED;
        end else begin
          // Clear the live mark and push the slot onto the free list.
          meta_we          = 1'b1;
          meta_wdata       = {1'b0, head_present_r, head_index_r};
          head_index_nxt   = req_idx;
          head_present_nxt = 1'b1;
        end
      end
      default: begin
        live = req_in_range && meta_live;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= frfl_pkg::ST_IDLE;
      head_index_r   <= '0;
      head_present_r <= 1'b0;
      used_count_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        head_index_r   <= head_index_nxt;
        head_present_r <= head_present_nxt;
        used_count_r   <= used_count_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Held item and result payload need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      slot_r <= in_slot;
      data_r <= DATA_BITS'(in_record_data);
    end
    if (exec_go) begin
      out_status_r          <= status;
      out_result_slot_r     <= SLW'(rslot_ext);
      out_read_data_r       <= DW'(rdata);
      out_slot_live_r       <= live;
      out_free_head_r       <= head_present_nxt ? SLW'(head_index_nxt) : '0;
      out_free_head_valid_r <= head_present_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_slot     = out_result_slot_r;
  assign out_read_data       = out_read_data_r;
  assign out_slot_live       = out_slot_live_r;
  assign out_free_head       = out_free_head_r;
  assign out_free_head_valid = out_free_head_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // An accepted item occupies the next cycle, so no item follows directly.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input accepted in the cycle after an accept");

  // The used-slot count never passes the number of slots.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= SLOTS_C)
    else $error("used slot count exceeds the store size");

  // The free-list head always names a slot that has been handed out.
  a_head_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    head_present_r |-> (UW'(head_index_r) < used_count_r))
    else $error("free-list head beyond the used slots");

  // A finished result reaches the output register in the cycle after execute.
  a_exec_loads: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_valid && (state_r == frfl_pkg::ST_IDLE)))
    else $error("execute did not load the result register");

endmodule

>>> tb/fixed_record_free_list_store_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fixed_record_free_list_store_unit.
// Depends on frfl_pkg and the RTL of the block; it predicts every result item.
module fixed_record_free_list_store_unit_tb;

  localparam int OP_W       = frfl_pkg::OP_W;
  localparam int SLOT_W     = frfl_pkg::SLOT_W;
  localparam int DATA_W     = frfl_pkg::DATA_W;
  localparam int STATUS_W   = frfl_pkg::STATUS_W;
  localparam int SLOTS      = 1024;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_LINES  = 100;

  // The fourth operation code does nothing; the package has no name for it.
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  // One result item as the block should present it.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   read_data;
    logic                live;
    logic [SLOT_W-1:0]   head;
    logic                head_valid;
  } store_result_t;

  logic                clk;
  logic                rst_n               = 1'b0;
  logic                in_valid            = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op               = '0;
  logic [SLOT_W-1:0]   in_slot             = '0;
  logic [DATA_W-1:0]   in_record_data      = '0;
  logic                out_valid;
  logic                out_stall           = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_result_slot;
  logic [DATA_W-1:0]   out_read_data;
  logic                out_slot_live;
  logic [SLOT_W-1:0]   out_free_head;
  logic                out_free_head_valid;

  fixed_record_free_list_store_unit #(
    .SLOTS     (SLOTS),
    .DATA_BITS (DATA_W)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_slot             (in_slot),
    .in_record_data      (in_record_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_slot     (out_result_slot),
    .out_read_data       (out_read_data),
    .out_slot_live       (out_slot_live),
    .out_free_head       (out_free_head),
    .out_free_head_valid (out_free_head_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the store. It is updated in the order in which the block
  // accepts items, so it always matches what the block should hold.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] shadow_payload [SLOTS];
  bit                shadow_live    [SLOTS];
  // Bit 10 says whether the link points at another free slot.
  logic [SLOT_W:0]   shadow_link    [SLOTS];
  logic [SLOT_W-1:0] shadow_head    = '0;
  bit                shadow_head_ok = 1'b0;
  int                shadow_used    = 0;

  store_result_t pending_results [$];
  int            mismatch_count = 0;

  // Flags that the test tasks use to switch idling on and off, and the
  // request for one long hold-off of the result channel.
  bit tx_gaps_on   = 1'b1;
  bit rx_gaps_on   = 1'b1;
  int rx_hold_req  = 0;
  int rx_stall_left = 0;
  int idle_cycles  = 0;

  // Apply one operation to the shadow store and return the result item that
  // the block must produce for it.
  function automatic store_result_t apply_store_op(logic [OP_W-1:0] op,
                                                   logic [SLOT_W-1:0] slot,
                                                   logic [DATA_W-1:0] data);
    store_result_t     r;
    logic [SLOT_W-1:0] taken;
    r.status    = frfl_pkg::STS_OK;
    r.slot      = slot;
    r.read_data = '0;
    r.live      = 1'b0;
    case (op)
      frfl_pkg::OP_ADD: begin
        // A freed slot is always reused before the used region grows.
        if (shadow_head_ok) begin
          taken          = shadow_head;
          shadow_head_ok = shadow_link[taken][SLOT_W];
          shadow_head    = shadow_head_ok ? shadow_link[taken][SLOT_W-1:0] : '0;
          shadow_payload[taken] = data;
          shadow_live[taken]    = 1'b1;
          r.slot                = taken;
        end else if (shadow_used < SLOTS) begin
          taken = shadow_used[SLOT_W-1:0];
          shadow_used++;
          shadow_payload[taken] = data;
          shadow_live[taken]    = 1'b1;
          r.slot                = taken;
        end else begin
          r.status = frfl_pkg::STS_FULL;
        end
      end
      frfl_pkg::OP_READ: begin
        if (slot >= shadow_used) r.status = frfl_pkg::STS_RANGE;
        else r.read_data = shadow_payload[slot];
      end
      frfl_pkg::OP_DEL: begin
        if (slot >= shadow_used) begin
          r.status = frfl_pkg::STS_RANGE;
        end else if (!shadow_live[slot]) begin
          r.status = frfl_pkg::STS_DELETED;
        end else begin
          shadow_link[slot] = shadow_head_ok ? {1'b1, shadow_head} : '0;
          shadow_head       = slot;
          shadow_head_ok    = 1'b1;
          shadow_live[slot] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (r.slot < shadow_used) r.live = shadow_live[r.slot];
    r.head       = shadow_head_ok ? shadow_head : '0;
    r.head_valid = shadow_head_ok;
    return r;
  endfunction

  // Most gaps are short; a few are long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    // Printing is capped so that a badly broken block cannot flood the log.
    if (mismatch_count < MAX_LINES)
      $display("%0t: %s got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string what, logic [DATA_W-1:0] got,
                             logic [DATA_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender. It is entered and left at a rising edge; valid stays high from
  // one item to the next when no gap is chosen.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                           logic [DATA_W-1:0] data);
    int            gap;
    store_result_t predicted;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_slot        <= slot;
    in_record_data <= data;
    do @(posedge clk); while (in_stall);
    predicted       = apply_store_op(op, slot, data);
    pending_results = {pending_results, predicted};
  endtask

  function automatic logic [DATA_W-1:0] random_data();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SLOT_W-1:0] any_slot();
    return SLOT_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // Slot for read and delete: mostly one in the used region, sometimes any.
  function automatic logic [SLOT_W-1:0] random_slot();
    if (shadow_used > 0 && $urandom_range(0, 99) < 85)
      return SLOT_W'($urandom_range(0, shadow_used - 1));
    return any_slot();
  endfunction

  // Stop offering items and wait until every result item has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or one long hold-off counted here when asked.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      rx_stall_left = 0;
    end else if (rx_hold_req > 0) begin
      rx_stall_left = rx_hold_req - 1;
      rx_hold_req   = 0;
      out_stall     <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall <= 1'b1;
    end else if (rx_gaps_on) begin
      rx_stall_left = pick_gap();
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every accepted result item is compared with the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    store_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, slot", DATA_W'(out_result_slot), '0);
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_W'(out_status), DATA_W'(want.status));
        check_field("result_slot", DATA_W'(out_result_slot), DATA_W'(want.slot));
        check_field("read_data", out_read_data, want.read_data);
        check_field("slot_live", DATA_W'(out_slot_live), DATA_W'(want.live));
        check_field("free_head", DATA_W'(out_free_head), DATA_W'(want.head));
        check_field("free_head_valid", DATA_W'(out_free_head_valid),
                    DATA_W'(want.head_valid));
      end
    end
  end

  // Watchdog: the run ends when neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every operation, the field extremes and the range and deleted errors on a fresh store.
  task automatic test_directed_basics();
    send_item(frfl_pkg::OP_READ, 10'd0, '0);     // nothing used yet: out of range
    send_item(frfl_pkg::OP_DEL, 10'd1023, '0);   // out of range
    send_item(OP_NOP, 10'd1023, '1);             // no-op echoes the slot
    send_item(frfl_pkg::OP_ADD, 10'd1023, '1);   // fresh slot 0, slot field ignored
    send_item(frfl_pkg::OP_ADD, 10'd0, '0);      // fresh slot 1
    send_item(frfl_pkg::OP_ADD, 10'd0, 64'h8000_0000_0000_0001);
    send_item(frfl_pkg::OP_READ, 10'd0, '0);
    send_item(frfl_pkg::OP_READ, 10'd1, '1);
    send_item(frfl_pkg::OP_READ, 10'd2, '0);
    send_item(frfl_pkg::OP_READ, 10'd3, '0);     // just past the used region
    send_item(frfl_pkg::OP_DEL, 10'd1, '0);
    send_item(frfl_pkg::OP_DEL, 10'd1, '0);      // already deleted
    send_item(frfl_pkg::OP_READ, 10'd1, '0);     // deleted slot keeps its payload
    send_item(frfl_pkg::OP_DEL, 10'd2, '0);
    send_item(frfl_pkg::OP_DEL, 10'd0, '0);      // free list is now 0, 2, 1
    send_item(OP_NOP, 10'd0, '0);
    // Adds take the freed slots back in last-in first-out order.
    send_item(frfl_pkg::OP_ADD, 10'd0, 64'h0123_4567_89AB_CDEF);
    send_item(frfl_pkg::OP_ADD, 10'd0, 64'hFEDC_BA98_7654_3210);
    send_item(frfl_pkg::OP_ADD, 10'd0, 64'h5555_AAAA_5555_AAAA);
    send_item(frfl_pkg::OP_ADD, 10'd0, 64'hAAAA_5555_AAAA_5555);  // fresh slot 3
    send_item(frfl_pkg::OP_DEL, 10'd3, '0);
    send_item(frfl_pkg::OP_DEL, 10'd5, '0);      // out of range
    send_item(frfl_pkg::OP_READ, 10'd3, '0);
    wait_drained();
  endtask

  // Random operations with random content; adds dominate so the store grows.
  task automatic test_random_mix(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      // Alternate stretches with idling on both sides and with idling on one side only.
      if (i % 50 == 0) begin
        tx_gaps_on = ((i / 50) % 3) != 2;
        rx_gaps_on = ((i / 50) % 3) != 1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 45)      send_item(frfl_pkg::OP_ADD, any_slot(), random_data());
      else if (roll < 70) send_item(frfl_pkg::OP_READ, random_slot(), random_data());
      else if (roll < 95) send_item(frfl_pkg::OP_DEL, random_slot(), random_data());
      else                send_item(OP_NOP, any_slot(), random_data());
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the block fills up and has to stall its input.
  task automatic test_receiver_holdoff();
    tx_gaps_on  = 1'b0;
    rx_hold_req = 300;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_item(frfl_pkg::OP_ADD, '0, random_data());
      else if (i % 3 == 1) send_item(frfl_pkg::OP_READ, random_slot(), '0);
      else send_item(frfl_pkg::OP_DEL, random_slot(), '0);
    end
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  // Fill every slot, then exercise the full store and the highest slot.
  task automatic test_store_full();
    while (shadow_used < SLOTS || shadow_head_ok)
      send_item(frfl_pkg::OP_ADD, any_slot(), random_data());
    repeat (4) send_item(frfl_pkg::OP_ADD, any_slot(), random_data());
    send_item(frfl_pkg::OP_READ, 10'd1023, '0);
    send_item(frfl_pkg::OP_DEL, 10'd1023, '0);
    send_item(frfl_pkg::OP_DEL, 10'd1023, '0);   // already deleted
    send_item(frfl_pkg::OP_READ, 10'd1023, '0);
    send_item(OP_NOP, 10'd1023, '1);
    send_item(frfl_pkg::OP_ADD, 10'd0, '1);      // takes slot 1023 back
    send_item(frfl_pkg::OP_ADD, 10'd0, '1);      // full again
    send_item(frfl_pkg::OP_READ, 10'd1023, '0);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_random_mix(150);
    test_receiver_holdoff();
    test_store_full();
    test_random_mix(60);

    // Let a stray extra result show up before the verdict.
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", DATA_W'(pending_results.size()), '0);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
